[design/f64a_pkg.sv]
// Shared types and constants for the binary64 round-down adder pipeline.
// No dependencies; imported by every stage module and the top level.
package f64a_pkg;

  localparam int unsigned EXP_W  = 11;
  localparam int unsigned FRAC_W = 52;
  localparam int unsigned SIG_W  = 63;
  localparam int unsigned EX_W   = 13;

  localparam logic [SIG_W-1:0] BIT62 = 63'h4000_0000_0000_0000;
  localparam logic [SIG_W-1:0] BIT61 = 63'h2000_0000_0000_0000;
  localparam logic [63:0]      NEG_ZERO = 64'h8000_0000_0000_0000;
  localparam logic [63:0]      RND_INC  = 64'h0000_0000_0000_03FF;
  localparam logic [EX_W-1:0]  EQ_BIAS  = 13'd10;

  // aligned operands, output of stage 1
  typedef struct packed {
    logic                   neg;
    logic                   is_sub;
    logic                   zero_add;
    logic signed [EX_W-1:0] ex;
    logic [SIG_W-1:0]       hi_op;
    logic [SIG_W-1:0]       lo_op;
  } aln_t;

  // unrounded magnitude, output of stages 2 and 3
  typedef struct packed {
    logic                   neg;
    logic signed [EX_W-1:0] ex;
    logic [SIG_W-1:0]       sig;
    logic                   spec_vld;
    logic [63:0]            spec;
  } mag_t;

endpackage

[design/f64a_align.sv]
// Stage 1: operand unpack, exponent compare, swap and sticky alignment shift.
// Depends on f64a_pkg.
module f64a_align import f64a_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_i,
  input  logic [63:0] opa,
  input  logic [63:0] opb,
  output logic        vld_r,
  output aln_t        aln_r
);

  function automatic logic [SIG_W-1:0] sticky_shr(input logic [SIG_W-1:0] x,
                                                  input logic [EXP_W-1:0] sh);
    logic [5:0]       sh6;
    logic [SIG_W-1:0] mask;
    sh6  = sh[5:0];
    mask = (63'd1 << sh6) - 63'd1;
    if (sh >= EXP_W'(SIG_W)) begin
      sticky_shr = {62'd0, |x};
    end else begin
      sticky_shr = (x >> sh6) | SIG_W'(|(x & mask));
    end
  endfunction

  logic              sa, sb, swap, eq;
  logic [EXP_W-1:0]  ea, eb, el, es, d;
  logic [FRAC_W-1:0] fa, fb, fl, fs;
  logic [SIG_W-1:0]  pre;
  aln_t              aln_nxt;

  always_comb begin
    sa   = opa[63];
    sb   = opb[63];
    ea   = opa[62:52];
    eb   = opb[62:52];
    fa   = opa[51:0];
    fb   = opb[51:0];
    swap = eb > ea;
    el   = swap ? eb : ea;
    es   = swap ? ea : eb;
    fl   = swap ? fb : fa;
    fs   = swap ? fa : fb;
    d    = el - es;
    eq   = (d == '0);
    pre  = '0;
    aln_nxt.is_sub   = sa ^ sb;
    aln_nxt.neg      = sa ^ ((sa ^ sb) & swap);
    aln_nxt.zero_add = 1'b0;
    if (!(sa ^ sb)) begin
      if (eq) begin
        aln_nxt.zero_add = (ea == '0);
        aln_nxt.hi_op    = SIG_W'({fa, 9'd0}) | ((ea == '0) ? '0 : BIT62);
        aln_nxt.lo_op    = SIG_W'({fb, 9'd0});
        aln_nxt.ex       = EX_W'(ea);
      end else begin
        pre           = SIG_W'({fs, 9'd0}) + ((es != '0) ? BIT61 : '0);
        aln_nxt.hi_op = SIG_W'({fl, 9'd0}) + BIT61;
        aln_nxt.lo_op = sticky_shr(pre, d);
        aln_nxt.ex    = EX_W'(el);
      end
    end else begin
      if (eq) begin
        aln_nxt.hi_op = SIG_W'(fa);
        aln_nxt.lo_op = SIG_W'(fb);
        aln_nxt.ex    = ((ea != '0) ? EX_W'(ea) - EX_W'(1) : '0) + EQ_BIAS;
      end else begin
        pre           = (es != '0) ? (BIT62 + SIG_W'({fs, 10'd0})) : SIG_W'({fs, 11'd0});
        aln_nxt.hi_op = SIG_W'({fl, 10'd0}) | BIT62;
        aln_nxt.lo_op = sticky_shr(pre, d);
        aln_nxt.ex    = EX_W'(el) - EX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      aln_r <= aln_nxt;
    end
  end

endmodule

[design/f64a_addsub.sv]
// Stage 2: significand add or subtract, sign fix-up and special results.
// Depends on f64a_pkg.
module f64a_addsub import f64a_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic vld_i,
  input  aln_t aln,
  output logic vld_r,
  output mag_t mag_r
);

  logic [SIG_W-1:0] sum;
  logic [63:0]      dif, rdif;
  mag_t             mag_nxt;

  always_comb begin
    sum  = aln.hi_op + aln.lo_op;
    dif  = {1'b0, aln.hi_op} - {1'b0, aln.lo_op};
    rdif = {1'b0, aln.lo_op} - {1'b0, aln.hi_op};
    mag_nxt.neg      = aln.neg;
    mag_nxt.ex       = aln.ex;
    mag_nxt.sig      = sum;
    mag_nxt.spec_vld = 1'b0;
    mag_nxt.spec     = {aln.neg, 63'd0} + 64'(sum[62:9]);
    if (!aln.is_sub) begin
      mag_nxt.spec_vld = aln.zero_add;
    end else if (dif == '0) begin
      mag_nxt.spec_vld = 1'b1;
      mag_nxt.spec     = NEG_ZERO;
    end else if (dif[63]) begin
      mag_nxt.neg = !aln.neg;
      mag_nxt.sig = rdif[62:0];
    end else begin
      mag_nxt.sig = dif[62:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
    end
  end

endmodule

[design/f64a_norm.sv]
// Stage 3: leading-zero count and normalizing left shift.
// Depends on f64a_pkg.
module f64a_norm import f64a_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic vld_i,
  input  mag_t mag,
  output logic vld_r,
  output mag_t mag_r
);

  logic [5:0] lz;
  mag_t       mag_nxt;

  always_comb begin
    lz = '0;
    for (int i = 0; i < SIG_W; i++) begin
      if (mag.sig[i]) begin
        lz = 6'(SIG_W - 1 - i);
      end
    end
    mag_nxt     = mag;
    mag_nxt.sig = mag.sig << lz;
    mag_nxt.ex  = mag.ex - EX_W'(lz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
    end
  end

endmodule

[design/f64a_round.sv]
// Stage 4: directed rounding toward minus infinity and final pack.
// Depends on f64a_pkg.
module f64a_round import f64a_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_i,
  input  mag_t        mag,
  output logic        vld_r,
  output logic [63:0] res_r
);

  logic [63:0] rnd, res_nxt;

  always_comb begin
    rnd     = {1'b0, mag.sig} + (mag.neg ? RND_INC : '0);
    res_nxt = {mag.neg, 63'd0} + {mag.ex[11:0], 52'd0} + 64'(rnd[63:10]);
    if (mag.spec_vld) begin
      res_nxt = mag.spec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule

[design/fp64_add_round_down.sv]
// Binary64 adder, round toward minus infinity. Four register stages (align,
// add/subtract, normalize, round/pack). One request is taken every cycle while
// in_stall is low. Each stage holds only while its successor is full and
// stalled, so bubbles are squeezed out and a stalled output does not block a
// partly empty pipeline. NaN, infinity, subnormal and overflow get no special
// handling; exact cancellation gives -0.
// Depends on f64a_pkg and the four f64a stage modules.
module fp64_add_round_down import f64a_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_operand_a,
  input  logic [63:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_sum_bits
);

  logic en1, en2, en3, en4;
  logic v1_r, v2_r, v3_r;
  aln_t aln_r;
  mag_t mag2_r, mag3_r;

  assign en4      = !out_valid || !out_stall;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  f64a_align u_align (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en1),
    .vld_i (in_valid),
    .opa   (in_operand_a),
    .opb   (in_operand_b),
    .vld_r (v1_r),
    .aln_r (aln_r)
  );

  f64a_addsub u_addsub (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en2),
    .vld_i (v1_r),
    .aln   (aln_r),
    .vld_r (v2_r),
    .mag_r (mag2_r)
  );

  f64a_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en3),
    .vld_i (v2_r),
    .mag   (mag2_r),
    .vld_r (v3_r),
    .mag_r (mag3_r)
  );

  f64a_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en4),
    .vld_i (v3_r),
    .mag   (mag3_r),
    .vld_r (out_valid),
    .res_r (out_sum_bits)
  );

`ifndef NO_ASSERTIONS
  a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && out_valid && out_stall))
    else $error("input stalled with a free pipeline slot");

  a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !en2) |=> (v1_r && $stable(aln_r)))
    else $error("stage 1 request lost while held");

  a_norm_msb: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !mag3_r.spec_vld) |-> mag3_r.sig[62])
    else $error("significand not normalized");
`endif

endmodule

[sim/fp64_add_round_down_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the binary64 round-down adder pipeline.
// Depends on fp64_add_round_down and f64a_pkg; predicts each sum in place.
module fp64_add_round_down_tb;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] in_operand_a;
  logic [63:0] in_operand_b;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_sum_bits;

  logic [63:0] sum_queue[$];
  int          mismatches;
  int          idle_cycles;
  bit          rx_hold;
  bit          rx_random;

  localparam int WATCHDOG = 5000;

  fp64_add_round_down uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_stall(out_stall), .out_sum_bits(out_sum_bits)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic logic [63:0] jam_shr(logic [63:0] v, int unsigned d);
    logic [63:0] lost;
    if (d == 0) return v;
    if (d < 63) begin
      lost = v << (64 - d);
      return (v >> d) | {63'd0, lost != 0};
    end
    return {63'd0, v != 0};
  endfunction

  function automatic int unsigned clz64(logic [63:0] v);
    int unsigned n;
    n = 0;
    if (v == 0) return 64;
    while (!v[63]) begin
      v = v << 1;
      n++;
    end
    return n;
  endfunction

  function automatic logic [63:0] assemble(bit neg, int ex, logic [63:0] sig);
    logic [63:0] e64;
    e64 = 64'(signed'(ex));
    return ({neg, 63'd0}) + (e64 << 52) + sig;
  endfunction

  function automatic logic [63:0] round_down(bit neg, int ex, logic [63:0] sig);
    logic [63:0] inc;
    inc = neg ? 64'h3FF : 64'd0;
    return assemble(neg, ex, (sig + inc) >> 10);
  endfunction

  function automatic logic [63:0] add_magnitudes(logic [63:0] a, logic [63:0] b, bit neg);
    int          ea, eb, diff, ez;
    logic [63:0] fa, fb, sz;
    ea = int'(a[62:52]);
    eb = int'(b[62:52]);
    fa = {12'd0, a[51:0]};
    fb = {12'd0, b[51:0]};
    diff = ea - eb;
    if (diff == 0) begin
      if (ea == 0) return a + fb;
      ez = ea;
      sz = (64'h0020_0000_0000_0000 + fa + fb) << 9;
    end else begin
      fa = fa << 9;
      fb = fb << 9;
      if (diff < 0) begin
        ez = eb;
        if (ea != 0) fa = fa + 64'h2000_0000_0000_0000;
        fa = jam_shr(fa, -diff);
      end else begin
        ez = ea;
        if (eb != 0) fb = fb + 64'h2000_0000_0000_0000;
        fb = jam_shr(fb, diff);
      end
      sz = 64'h2000_0000_0000_0000 + fa + fb;
      if (sz < 64'h4000_0000_0000_0000) begin
        ez--;
        sz = sz << 1;
      end
    end
    return round_down(neg, ez, sz);
  endfunction

  function automatic logic [63:0] sub_magnitudes(logic [63:0] a, logic [63:0] b, bit neg);
    int          ea, eb, diff, ez;
    int unsigned lz, sh;
    logic [63:0] fa, fb, sz, d;
    ea = int'(a[62:52]);
    eb = int'(b[62:52]);
    fa = {12'd0, a[51:0]};
    fb = {12'd0, b[51:0]};
    diff = ea - eb;
    if (diff == 0) begin
      if (fa == fb) return 64'h8000_0000_0000_0000;
      if (ea != 0) ea--;
      if (fa < fb) begin
        neg = !neg;
        d = fb - fa;
      end else d = fa - fb;
      sh = clz64(d) - 11;
      return assemble(neg, ea - int'(sh), d << sh);
    end
    fa = fa << 10;
    fb = fb << 10;
    if (diff < 0) begin
      neg = !neg;
      fa = fa + ((ea != 0) ? 64'h4000_0000_0000_0000 : fa);
      fa = jam_shr(fa, -diff);
      fb = fb | 64'h4000_0000_0000_0000;
      ez = eb;
      sz = fb - fa;
    end else begin
      fb = fb + ((eb != 0) ? 64'h4000_0000_0000_0000 : fb);
      fb = jam_shr(fb, diff);
      fa = fa | 64'h4000_0000_0000_0000;
      ez = ea;
      sz = fa - fb;
    end
    ez = ez - 1;
    lz = clz64(sz);
    sh = (lz != 0) ? lz - 1 : 0;
    ez = ez - int'(sh);
    if (sh >= 10) return assemble(neg, ez, sz << (sh - 10));
    return round_down(neg, ez, sz << sh);
  endfunction

  function automatic logic [63:0] predict_sum(logic [63:0] a, logic [63:0] b);
    if (a[63] == b[63]) return add_magnitudes(a, b, a[63]);
    return sub_magnitudes(a, b, a[63]);
  endfunction

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(8, 30);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic send_request(logic [63:0] a, logic [63:0] b, bit gaps);
    int unsigned g;
    g = gaps ? gap_len() : 0;
    repeat (g) @(negedge clk);
    in_operand_a = a;
    in_operand_b = b;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sum_queue.push_back(predict_sum(a, b));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_normal(bit sgn, int lo, int hi);
    logic [10:0] e;
    logic [63:0] r;
    e = 11'($urandom_range(lo, hi));
    r = rand64();
    return {sgn, e, r[51:0]};
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (sum_queue.size() == 0) begin
        $error("unexpected result sum_bits actual %h", out_sum_bits);
        mismatches++;
      end else begin
        logic [63:0] exp_sum;
        exp_sum = sum_queue.pop_front();
        if (out_sum_bits !== exp_sum) begin
          $error("sum_bits expected %h actual %h", exp_sum, out_sum_bits);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk) begin
    int unsigned g;
    if (rx_hold) out_stall <= 1'b1;
    else if (!rx_random) out_stall <= 1'b0;
    else begin
      g = gap_len();
      out_stall <= (g != 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic test_directed();
    logic [63:0] one, two, maxn, minn;
    one  = 64'h3FF0_0000_0000_0000;
    two  = 64'h4000_0000_0000_0000;
    maxn = 64'h7FEF_FFFF_FFFF_FFFF;
    minn = 64'h0010_0000_0000_0000;
    send_request(64'd0, 64'd0, 0);
    send_request(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 0);
    send_request(64'd0, 64'h8000_0000_0000_0000, 0);
    send_request(one, one | 64'h8000_0000_0000_0000, 0);
    send_request(maxn, maxn | 64'h8000_0000_0000_0000, 0);
    send_request(one, two, 0);
    send_request(one | 64'h8000_0000_0000_0000, 64'hBCA0_0000_0000_0001, 0);
    send_request(one, 64'hBCA0_0000_0000_0001, 0);
    send_request(maxn, maxn, 0);
    send_request(minn, minn | 64'h8000_0000_0000_0001, 0);
    send_request(64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 0);
    send_request(64'h7FF8_0000_0000_0001, one, 0);
    send_request(64'h0000_0000_0000_0001, 64'h8000_0000_0000_0003, 0);
    send_request(64'h000F_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001, 0);
    send_request(one, 64'h0000_0000_0000_0005, 0);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 0);
    send_request(one, 64'h8010_0000_0000_0000, 0);
    send_request(64'h3FF0_0000_0000_0001, 64'hBFF0_0000_0000_0000, 0);
    send_request(64'h4340_0000_0000_0000, 64'hBFF0_0000_0000_0000, 0);
  endtask

  task automatic test_random(int n);
    logic [63:0] a, b;
    int          ea;
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: begin
          a = rand64();
          b = rand64();
        end
        1: begin
          ea = $urandom_range(1, 2046);
          a = rand_normal(1'($urandom_range(0, 1)), ea, ea);
          b = rand_normal(1'($urandom_range(0, 1)), ea, ea);
        end
        2: begin
          ea = $urandom_range(70, 1900);
          a = rand_normal(1'($urandom_range(0, 1)), ea, ea);
          b = rand_normal(1'($urandom_range(0, 1)), ea - $urandom_range(0, 64),
                          ea + $urandom_range(0, 3));
        end
        3: begin
          a = rand_normal(1'($urandom_range(0, 1)), 1, 2046);
          b = {~a[63], a[62:0] ^ (63'd1 << $urandom_range(0, 51))};
        end
        4: begin
          a = rand_normal(1'($urandom_range(0, 1)), 1, 2046);
          b = ($urandom_range(0, 1) == 0) ? {$urandom_range(0, 1) == 1, 63'd0}
                                          : {~a[63], a[62:0]};
        end
        default: begin
          a = rand_normal(1'($urandom_range(0, 1)), 1, 2046);
          b = rand_normal(1'($urandom_range(0, 1)), 1, 2046);
        end
      endcase
      if ($urandom_range(0, 1) == 1) send_request(b, a, 1);
      else send_request(a, b, 1);
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        rx_hold = 1'b1;
        repeat (40) @(posedge clk);
        rx_hold = 1'b0;
      end
      test_random(30);
    join
  endtask

  task automatic test_drain_pause();
    test_random(20);
    wait (sum_queue.size() == 0);
    repeat (6) @(posedge clk);
    @(negedge clk);
    test_random(20);
  endtask

  initial begin
    int unsigned w;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operand_a = '0;
    in_operand_b = '0;
    out_stall = 1'b0;
    rx_hold = 1'b0;
    rx_random = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    rx_random = 1'b1;
    test_random(900);
    test_backpressure();
    test_drain_pause();
    rx_random = 1'b0;
    test_random(200);
    rx_random = 1'b1;
    test_random(620);
    w = 0;
    while (sum_queue.size() != 0 && w < 20000) begin
      @(posedge clk);
      w++;
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && sum_queue.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
design/f64a_pkg.sv
design/f64a_align.sv
design/f64a_addsub.sv
design/f64a_norm.sv
design/f64a_round.sv
design/fp64_add_round_down.sv
sim/fp64_add_round_down_tb.sv
